>>> rtl/gbp_pkg.sv
// Shared types, constants and lighting functions of the gradient and bevel pixel generator.
// No dependencies; every other file in rtl imports this package.
package gbp_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIM_W      = 13;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 24;
   localparam int OPND_W     = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
   localparam int NUM_W      = CHAN_W + OPND_W;
   localparam int EXT_W      = OPND_W + 2;
   localparam int DIV_STEPS  = CHAN_W;
   localparam int NCHAN      = 3;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_START  = 3'd2;
   localparam logic [2:0] REG_END    = 3'd3;
   localparam logic [2:0] REG_BORDER = 3'd4;
   localparam logic [2:0] REG_GRAD   = 3'd5;
   localparam logic [2:0] REG_RELIEF = 3'd6;
   localparam logic [2:0] REG_EDGE   = 3'd7;

   localparam logic [1:0] GRAD_VERT  = 2'd0;
   localparam logic [1:0] GRAD_DIAG  = 2'd1;
   localparam logic [1:0] GRAD_CROSS = 2'd2;

   localparam logic [1:0] RELIEF_FLAT   = 2'd0;
   localparam logic [1:0] RELIEF_RAISED = 2'd1;

   localparam logic [1:0] EDGE_BORDER = 2'd1;
   localparam logic [1:0] EDGE_BEVEL1 = 2'd2;
   localparam logic [1:0] EDGE_BEVEL2 = 2'd3;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] end_color;
      logic [COLOR_W-1:0] border_color;
      logic [1:0]         gradient_mode;
      logic [1:0]         relief_mode;
      logic [1:0]         edge_style;
   } cfg_type;

   typedef struct packed {
      logic oor;
      logic up;
      logic down;
      logic border;
   } side_type;

   function automatic logic [CHAN_W-1:0] brighten(input logic [CHAN_W-1:0] v);
      logic [CHAN_W:0] t;
      t = {1'b0, v} + {2'b0, v[CHAN_W-1:1]};
      return t[CHAN_W] ? {CHAN_W{1'b1}} : t[CHAN_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] darken(input logic [CHAN_W-1:0] v);
      return {1'b0, v[CHAN_W-1:1]} + {2'b0, v[CHAN_W-1:2]};
   endfunction

   function automatic logic [CHAN_W-1:0] light(input logic [CHAN_W-1:0] v, input logic up,
                                               input logic down, input logic raised);
      logic [CHAN_W-1:0] r;
      if (up && down) begin
         r = darken(brighten(v));
      end else if (up) begin
         r = raised ? brighten(v) : darken(v);
      end else if (down) begin
         r = raised ? darken(v) : brighten(v);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> rtl/gbp_front.sv
// Input register, range check, edge classification and gradient numerator products.
// Depends on gbp_pkg.
module gbp_front import gbp_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  cfg_type                          cfg,
   input  logic                             in_valid,
   input  logic [COORD_BITS-1:0]            in_column,
   input  logic [COORD_BITS-1:0]            in_row,
   output logic                             out_valid,
   output side_type                         out_side,
   output logic [NCHAN-1:0][NUM_W-1:0]      out_numc,
   output logic [NCHAN-1:0][NUM_W-1:0]      out_numr
);

   logic                        a_valid_ff;
   logic [COORD_BITS-1:0]       a_col_ff, a_row_ff;
   logic                        b_valid_ff;
   side_type                    b_side_ff, b_side_in;
   logic [NCHAN-1:0][NUM_W-1:0] b_numc_ff, b_numc_in, b_numr_ff, b_numr_in;

   logic [EXT_W-1:0]  x_e, y_e, w_e, h_e, cx_e;
   logic [OPND_W-1:0] xsel;
   logic              flat, bevel1, bevel2;
   logic [CHAN_W-1:0] s, e, mag;

   always_comb begin
      x_e    = EXT_W'(a_col_ff);
      y_e    = EXT_W'(a_row_ff);
      w_e    = EXT_W'(cfg.width);
      h_e    = EXT_W'(cfg.height);
      cx_e   = w_e - EXT_W'(1) - x_e;
      xsel   = (cfg.gradient_mode == GRAD_CROSS) ? cx_e[OPND_W-1:0] : x_e[OPND_W-1:0];
      flat   = (cfg.relief_mode == RELIEF_FLAT);
      bevel1 = !flat && (cfg.edge_style == EDGE_BEVEL1);
      bevel2 = !flat && (cfg.edge_style == EDGE_BEVEL2);

      b_side_in.oor    = (x_e >= w_e) || (y_e >= h_e);
      b_side_in.border = flat && (cfg.edge_style == EDGE_BORDER) &&
                         ((x_e == '0) || (y_e == '0) ||
                          (x_e + EXT_W'(1) == w_e) || (y_e + EXT_W'(1) == h_e));
      b_side_in.up   = 1'b0;
      b_side_in.down = 1'b0;
      if (bevel1) begin
         if ((x_e >= EXT_W'(1)) && (x_e + EXT_W'(2) <= w_e)) begin
            b_side_in.up   = (y_e == '0);
            b_side_in.down = (y_e + EXT_W'(1) == h_e);
         end else begin
            b_side_in.up   = (x_e == '0);
            b_side_in.down = (x_e + EXT_W'(1) == w_e);
         end
      end else if (bevel2) begin
         if ((x_e >= EXT_W'(2)) && (x_e + EXT_W'(3) <= w_e)) begin
            b_side_in.up   = (y_e == EXT_W'(1));
            b_side_in.down = (y_e + EXT_W'(2) == h_e);
         end else if ((y_e >= EXT_W'(1)) && (y_e + EXT_W'(2) <= h_e)) begin
            b_side_in.up   = (x_e == EXT_W'(1));
            b_side_in.down = (x_e + EXT_W'(2) == w_e);
         end
      end

      for (int k = 0; k < NCHAN; k++) begin
         s   = cfg.start_color[CHAN_W*k +: CHAN_W];
         e   = cfg.end_color[CHAN_W*k +: CHAN_W];
         mag = (e >= s) ? (e - s) : (s - e);
         b_numc_in[k] = NUM_W'(mag) * NUM_W'(xsel);
         b_numr_in[k] = NUM_W'(mag) * NUM_W'(a_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_col_ff  <= in_column;
         a_row_ff  <= in_row;
         b_side_ff <= b_side_in;
         b_numc_ff <= b_numc_in;
         b_numr_ff <= b_numr_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign out_numc  = b_numc_ff;
   assign out_numr  = b_numr_ff;

endmodule

>>> rtl/gbp_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient below 256.
// Depends on gbp_pkg.
module gbp_div import gbp_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num,
   input  logic [DIM_W-1:0]  divisor,
   output logic [CHAN_W-1:0] quot
);

   logic [DIV_STEPS-1:0][NUM_W-1:0]  rem_ff, rem_in;
   logic [DIV_STEPS-1:0][CHAN_W-1:0] q_ff, q_in;
   logic [NUM_W-1:0]  src_rem, trial;
   logic [CHAN_W-1:0] src_q;

   always_comb begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (i == 0) begin
            src_rem = num;
            src_q   = '0;
         end else begin
            src_rem = rem_ff[i-1];
            src_q   = q_ff[i-1];
         end
         trial = NUM_W'(divisor) << (DIV_STEPS - 1 - i);
         if (src_rem >= trial) begin
            rem_in[i] = src_rem - trial;
            q_in[i]   = src_q | (CHAN_W'(1) << (DIV_STEPS - 1 - i));
         end else begin
            rem_in[i] = src_rem;
            q_in[i]   = src_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

>>> rtl/gbp_shade.sv
// Gradient combine stage, then border, bevel lighting and range masking into the output register.
// Depends on gbp_pkg.
module gbp_shade import gbp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cfg_type                      cfg,
   input  logic                         in_valid,
   input  side_type                     in_side,
   input  logic [NCHAN-1:0][CHAN_W-1:0] in_qc,
   input  logic [NCHAN-1:0][CHAN_W-1:0] in_qr,
   output logic                         out_valid,
   output logic [NCHAN-1:0][CHAN_W-1:0] out_color,
   output logic                         out_oor
);

   logic                         s1_valid_ff;
   side_type                     s1_side_ff;
   logic [NCHAN-1:0][CHAN_W-1:0] s1_color_ff, s1_color_in;
   logic                         o_valid_ff;
   logic [NCHAN-1:0][CHAN_W-1:0] o_color_ff, o_color_in;
   logic                         o_oor_ff;

   logic [CHAN_W-1:0] s, e;
   logic [CHAN_W+1:0] tc, tr, sum, half, val;
   logic              neg, raised;

   always_comb begin
      for (int k = 0; k < NCHAN; k++) begin
         s    = cfg.start_color[CHAN_W*k +: CHAN_W];
         e    = cfg.end_color[CHAN_W*k +: CHAN_W];
         neg  = (e < s);
         tc   = neg ? ((CHAN_W+2)'(0) - {2'b0, in_qc[k]}) : {2'b0, in_qc[k]};
         tr   = neg ? ((CHAN_W+2)'(0) - {2'b0, in_qr[k]}) : {2'b0, in_qr[k]};
         sum  = tc + tr;
         half = $unsigned($signed(sum + {{(CHAN_W+1){1'b0}}, sum[CHAN_W+1]}) >>> 1);
         case (cfg.gradient_mode) inside
            GRAD_VERT:             val = {2'b0, s} + tr;
            GRAD_DIAG, GRAD_CROSS: val = {2'b0, s} + half;
            default:               val = '0;
         endcase
         s1_color_in[k] = val[CHAN_W-1:0];
      end

      raised = (cfg.relief_mode == RELIEF_RAISED);
      for (int k = 0; k < NCHAN; k++) begin
         if (s1_side_ff.oor) begin
            o_color_in[k] = '0;
         end else if (s1_side_ff.border) begin
            o_color_in[k] = cfg.border_color[CHAN_W*k +: CHAN_W];
         end else begin
            o_color_in[k] = light(s1_color_ff[k], s1_side_ff.up, s1_side_ff.down, raised);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         o_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff  <= in_side;
         s1_color_ff <= s1_color_in;
         o_color_ff  <= o_color_in;
         o_oor_ff    <= s1_side_ff.oor;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_color = o_color_ff;
   assign out_oor   = o_oor_ff;

endmodule

>>> rtl/gradient_bevel_pixel_gen_top.sv
// Top level of the gradient and bevel pixel generator: registers, divider array, pipeline control.
// Depends on gbp_pkg, gbp_front, gbp_div and gbp_shade.

// One request (column, row) gives one pixel colour. The block takes a request every clock
// while no stalled result waits at the output; a request passes through two front stages
// (capture, then range check and products), eight divider stages that produce one quotient
// bit each, a gradient combine stage and the lighting stage that loads the output register.
// The whole pipeline holds while a result waits and is stalled.
// Write the configuration registers only while no request is in flight.
module gradient_bevel_pixel_gen_top import gbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_column,
   input  logic [COORD_BITS-1:0] req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic                  rsp_out_of_range,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [COLOR_W-1:0]    csr_data
);

   cfg_type cfg_ff;
   logic    advance;

   logic                         f_valid;
   side_type                     f_side;
   logic [NCHAN-1:0][NUM_W-1:0]  f_numc, f_numr;
   logic [NCHAN-1:0][CHAN_W-1:0] qc, qr;

   logic [DIV_STEPS-1:0]           d_valid_ff;
   side_type [DIV_STEPS-1:0]       d_side_ff;

   logic [NCHAN-1:0][CHAN_W-1:0] color;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width         <= DIM_W'(1);
         cfg_ff.height        <= DIM_W'(1);
         cfg_ff.start_color   <= '0;
         cfg_ff.end_color     <= '0;
         cfg_ff.border_color  <= '0;
         cfg_ff.gradient_mode <= GRAD_VERT;
         cfg_ff.relief_mode   <= RELIEF_FLAT;
         cfg_ff.edge_style    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  cfg_ff.width         <= csr_data[DIM_W-1:0];
            REG_HEIGHT: cfg_ff.height        <= csr_data[DIM_W-1:0];
            REG_START:  cfg_ff.start_color   <= csr_data;
            REG_END:    cfg_ff.end_color     <= csr_data;
            REG_BORDER: cfg_ff.border_color  <= csr_data;
            REG_GRAD:   cfg_ff.gradient_mode <= csr_data[1:0];
            REG_RELIEF: cfg_ff.relief_mode   <= csr_data[1:0];
            REG_EDGE:   cfg_ff.edge_style    <= csr_data[1:0];
            default:    ;
         endcase
      end
   end

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   gbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_column (req_column),
      .in_row    (req_row),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_numc  (f_numc),
      .out_numr  (f_numr)
   );

   for (genvar k = 0; k < NCHAN; k++) begin : g_chan
      gbp_div u_div_col (
         .clock   (clock),
         .advance (advance),
         .num     (f_numc[k]),
         .divisor (cfg_ff.width),
         .quot    (qc[k])
      );
      gbp_div u_div_row (
         .clock   (clock),
         .advance (advance),
         .num     (f_numr[k]),
         .divisor (cfg_ff.height),
         .quot    (qr[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= '0;
      end else if (advance) begin
         d_valid_ff <= {d_valid_ff[DIV_STEPS-2:0], f_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_side_ff <= {d_side_ff[DIV_STEPS-2:0], f_side};
      end
   end

   gbp_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (d_valid_ff[DIV_STEPS-1]),
      .in_side   (d_side_ff[DIV_STEPS-1]),
      .in_qc     (qc),
      .in_qr     (qr),
      .out_valid (rsp_valid),
      .out_color (color),
      .out_oor   (rsp_out_of_range)
   );

   assign rsp_red   = color[2];
   assign rsp_green = color[1];
   assign rsp_blue  = color[0];

   a_oor_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
      else $error("out-of-range pixel not black");

   a_hold_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output backpressure");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(d_valid_ff) && $stable(d_side_ff))
      else $error("divider sideband moved while held");

endmodule
